@@ rtl/core/i2cw_pkg.sv @@
// Package for the write-only I2C master: item types, config struct,
// bus phase encoding and register reset values. No dependencies.
`timescale 1ns / 1ps

package i2cw_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEV_ADDR    = 2'd0,
    CFG_ACK_TIMEOUT = 2'd1,
    CFG_TICKS_UNIT  = 2'd2
  } cfg_idx_e;

  // Register reset values
  localparam logic [7:0] DevAddrReset    = 8'h78;
  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [7:0] TicksUnitReset  = 8'd1;

  // Bus phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_START_A   = 11'b000_0000_0010,
    PH_START_B   = 11'b000_0000_0100,
    PH_BIT_SETUP = 11'b000_0000_1000,
    PH_BIT_HIGH  = 11'b000_0001_0000,
    PH_BIT_LOW   = 11'b000_0010_0000,
    PH_ACK_REL   = 11'b000_0100_0000,
    PH_ACK_HIGH  = 11'b000_1000_0000,
    PH_ACK_WAIT  = 11'b001_0000_0000,
    PH_STOP_A    = 11'b010_0000_0000,
    PH_STOP_B    = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic       mode;
    logic       sda_in;
    logic [7:0] control_byte;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic finished;
    logic ack_missing;
  } result_t;

  typedef struct packed {
    logic [7:0] device_address_byte;
    logic [7:0] ack_timeout;
    logic [7:0] ticks_per_unit;
  } cfg_t;

endpackage

@@ rtl/core/i2cw_in_stage.sv @@
// Input register of the I2C write master: holds one accepted item.
// Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_in_stage import i2cw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  input  logic  fire_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Take a new item when empty or when the held one moves on this cycle
  assign in_stall_o = valid_q && !fire_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/core/i2cw_engine.sv @@
// Bus sequencer of the I2C write master: phase state, bit/byte counters,
// phase timer and ack wait; one item handled per fire. Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_engine import i2cw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  phase_e     phase_q, phase_d, show_ph;
  logic [1:0] byte_q, byte_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] data_q, data_d;
  logic [9:0] delay_q, delay_d;
  logic [7:0] wait_q, wait_d;
  logic       err_q, err_d;

  logic [7:0]  unit;
  logic [9:0]  phase_len;
  logic [10:0] delay_inc;
  logic        timer_done;
  logic        idle_now;
  logic        fin, miss;
  logic        bit_val;

  // Phase length in ticks; zero ticks per unit counts as one
  assign unit = (cfg_i.ticks_per_unit == 8'd0) ? 8'd1 : cfg_i.ticks_per_unit;

  always_comb begin
    case (phase_q)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: phase_len = {unit, 2'b00};
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW:        phase_len = {1'b0, unit, 1'b0};
      PH_ACK_REL, PH_ACK_HIGH:                      phase_len = {2'b00, unit};
      default:                                      phase_len = 10'd0;
    endcase
  end

  assign delay_inc  = {1'b0, delay_q} + 11'd1;
  assign timer_done = delay_inc >= {1'b0, phase_len};

  // Any code outside the busy phases behaves as idle
  assign idle_now = !(phase_q inside {PH_START_A, PH_START_B, PH_BIT_SETUP, PH_BIT_HIGH,
                                      PH_BIT_LOW, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_WAIT,
                                      PH_STOP_A, PH_STOP_B});

  // Next state
  always_comb begin
    phase_d = phase_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    data_d  = data_q;
    delay_d = delay_q;
    wait_d  = wait_q;
    err_d   = err_q;
    fin     = 1'b0;
    miss    = 1'b0;
    show_ph = phase_q;

    if (item_i.mode) begin
      // Request: start only from idle, otherwise ignored
      if (idle_now) begin
        ctrl_d  = item_i.control_byte;
        data_d  = item_i.data_byte;
        shift_d = cfg_i.device_address_byte;
        byte_d  = 2'd0;
        bit_d   = 3'd0;
        err_d   = 1'b0;
        phase_d = PH_START_A;
        delay_d = 10'd0;
        wait_d  = 8'd0;
        show_ph = PH_START_A;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
        end
        PH_ACK_WAIT: begin
          if (!item_i.sda_in) begin
            delay_d = 10'd0;
            wait_d  = 8'd0;
            if (byte_q < 2'd2) begin
              byte_d  = byte_q + 2'd1;
              shift_d = (byte_q == 2'd0) ? ctrl_q : data_q;
              bit_d   = 3'd0;
              phase_d = PH_BIT_SETUP;
            end else begin
              phase_d = PH_STOP_A;
            end
          end else if (wait_q >= cfg_i.ack_timeout) begin
            err_d   = 1'b1;
            phase_d = PH_STOP_A;
            delay_d = 10'd0;
            wait_d  = 8'd0;
          end else begin
            wait_d = wait_q + 8'd1;
          end
        end
        PH_START_A, PH_START_B, PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW,
        PH_ACK_REL, PH_ACK_HIGH, PH_STOP_A, PH_STOP_B: begin
          if (timer_done) begin
            delay_d = 10'd0;
            wait_d  = 8'd0;
            case (phase_q)
              PH_START_A:   phase_d = PH_START_B;
              PH_START_B:   phase_d = PH_BIT_SETUP;
              PH_BIT_SETUP: phase_d = PH_BIT_HIGH;
              PH_BIT_HIGH:  phase_d = PH_BIT_LOW;
              PH_BIT_LOW: begin
                shift_d = {shift_q[6:0], 1'b0};
                if (bit_q == 3'd7) begin
                  bit_d   = 3'd0;
                  phase_d = PH_ACK_REL;
                end else begin
                  bit_d   = bit_q + 3'd1;
                  phase_d = PH_BIT_SETUP;
                end
              end
              PH_ACK_REL:   phase_d = PH_ACK_HIGH;
              PH_ACK_HIGH:  phase_d = PH_ACK_WAIT;
              PH_STOP_A:    phase_d = PH_STOP_B;
              PH_STOP_B: begin
                fin     = 1'b1;
                miss    = err_q;
                phase_d = PH_IDLE;
              end
              default:      phase_d = PH_IDLE;
            endcase
          end else begin
            delay_d = delay_inc[9:0];
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Bus levels of the shown phase
  assign bit_val = shift_q[7];

  always_comb begin
    result_o.scl_level   = 1'b1;
    result_o.sda_level   = 1'b1;
    result_o.sda_drive   = 1'b1;
    result_o.busy_res    = 1'b1;
    result_o.finished    = fin;
    result_o.ack_missing = miss;
    case (show_ph)
      PH_START_A: begin
      end
      PH_START_B: result_o.sda_level = 1'b0;
      PH_BIT_SETUP, PH_BIT_LOW: begin
        result_o.scl_level = 1'b0;
        result_o.sda_level = bit_val;
      end
      PH_BIT_HIGH: result_o.sda_level = bit_val;
      PH_ACK_REL: begin
        result_o.scl_level = 1'b0;
        result_o.sda_drive = 1'b0;
      end
      PH_ACK_HIGH, PH_ACK_WAIT: result_o.sda_drive = 1'b0;
      PH_STOP_A: begin
        result_o.scl_level = 1'b0;
        result_o.sda_level = 1'b0;
      end
      PH_STOP_B: begin
      end
      default: result_o.busy_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      byte_q  <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      ctrl_q  <= 8'd0;
      data_q  <= 8'd0;
      delay_q <= 10'd0;
      wait_q  <= 8'd0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      data_q  <= data_d;
      delay_q <= delay_d;
      wait_q  <= wait_d;
      err_q   <= err_d;
    end
  end

endmodule

@@ rtl/core/i2cw_out_stage.sv @@
// Result register of the I2C write master: holds one result item until
// the consumer takes it. Depends on i2cw_pkg.
`timescale 1ns / 1ps

module i2cw_out_stage import i2cw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  result_t result_i,
  output logic    take_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign take_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = fire_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

@@ rtl/core/i2c_write_master.sv @@
// Write-only I2C master, one bus tick or request per item.
// An accepted item is held in the input register; its result is computed from it
// and registered in the result register once that register has room.
// Throughput: 1 item per cycle; the input stalls only while a stalled result
// sits in the result register and an item already waits in the input register.
// Reset (rst_ni low, async): bus idle, pipeline empty, registers at defaults.
`timescale 1ns / 1ps

module i2c_write_master import i2cw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic       sda_in_i,
  input  logic [7:0] control_byte_i,
  input  logic [7:0] data_byte_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       sda_drive_o,
  output logic       busy_res_o,
  output logic       finished_o,
  output logic       ack_missing_o,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   in_item, item;
  logic    item_valid;
  logic    take, fire;
  result_t res_comb, res_out;

  // Config registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address_byte <= DevAddrReset;
      cfg_q.ack_timeout         <= AckTimeoutReset;
      cfg_q.ticks_per_unit      <= TicksUnitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEV_ADDR:    cfg_q.device_address_byte <= cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout         <= cfg_data_i;
        CFG_TICKS_UNIT:  cfg_q.ticks_per_unit      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_item.mode         = mode_i;
  assign in_item.sda_in       = sda_in_i;
  assign in_item.control_byte = control_byte_i;
  assign in_item.data_byte    = data_byte_i;

  // Held item is processed when the result register has room
  assign fire = item_valid && take;

  i2cw_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .fire_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  i2cw_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (res_comb)
  );

  i2cw_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (res_comb),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_out)
  );

  assign scl_level_o   = res_out.scl_level;
  assign sda_level_o   = res_out.sda_level;
  assign sda_drive_o   = res_out.sda_drive;
  assign busy_res_o    = res_out.busy_res;
  assign finished_o    = res_out.finished;
  assign ack_missing_o = res_out.ack_missing;

  // A finishing result is still flagged busy
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> busy_res_o)
    else $error("finished result without busy");

  // Missing ack is reported only on the finishing result
  a_miss_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_missing_o |-> finished_o)
    else $error("ack_missing outside finished result");

  // Released SDA always reads as level high
  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> sda_level_o)
    else $error("released SDA with low level");

  // Input is only held off while an item waits in the input register
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid && !fire)
    else $error("input stalled with empty input register");

endmodule
